// ===== design/gsa_pkg.sv =====
package gsa_pkg;

  localparam int REQ_W = 3;
  localparam int STS_W = 2;
  localparam int CFG_W = 9;

  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INIT    = 3'd4;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STS_W-1:0] ST_INVALID = 2'd2;

  localparam logic [CFG_W-1:0] CFG_CAP_RESET = 9'd256;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [STS_W-1:0] status_t;
  typedef logic [CFG_W-1:0] cfg_t;

endpackage

// ===== design/gsa_ram.sv =====
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/generational_slot_allocator.sv =====
// Per beat: check and destroy pass S_CHK, create S_CPOP and S_CREATE (skipped when full),
// flush walks the pending list in S_FLUSH, init sweeps S_CLEAR (skipped for zero capacity);
// all end in S_DONE, which registers the result. A new beat is taken in the cycle its
// predecessor's result is registered, so none is taken before the last is through.
// Reset: synchronous, active low; afterwards a sweep of min(256, MAX_SLOTS) slots clears
// the generation memory and fills the free stack while in_ready stays low.
module generational_slot_allocator #(
  parameter int MAX_SLOTS = 256,
  parameter int GEN_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gsa_pkg::CFG_W-1:0]    cfg_slot_capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gsa_pkg::REQ_W-1:0]    in_req_type,
  input  logic [$clog2(MAX_SLOTS)-1:0] in_slot_index,
  input  logic [GEN_BITS-1:0]          in_handle_generation,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gsa_pkg::STS_W-1:0]    out_status,
  output logic [$clog2(MAX_SLOTS)-1:0] out_given_index,
  output logic [GEN_BITS-1:0]          out_given_generation,
  output logic                         out_handle_ok,
  output logic [$clog2(MAX_SLOTS):0]   out_freed_count
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CAP_W = IDX_W + 1;
  localparam int GW    = GEN_BITS + 1;
  localparam logic [CAP_W-1:0] MAX_C = CAP_W'(MAX_SLOTS);
  localparam logic [CAP_W-1:0] RST_CAP = (MAX_SLOTS < 256) ? CAP_W'(MAX_SLOTS) : CAP_W'(256);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CPOP   = 3'd1;
  localparam logic [2:0] S_CREATE = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  gsa_pkg::cfg_t          cap_cfg_r;
  logic [CAP_W-1:0]       active_cap_r, active_cap_nxt;
  logic [CAP_W-1:0]       free_top_r, free_top_nxt;
  logic [CAP_W-1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [CAP_W-1:0]       clr_ptr_r, clr_ptr_nxt;
  logic                   clr_rsp_r, clr_rsp_nxt;
  logic [CAP_W-1:0]       fl_i_r, fl_i_nxt;
  logic                   fl_v1_r, fl_v1_nxt;
  logic                   fl_v2_r, fl_v2_nxt;
  logic [IDX_W-1:0]       fl_s_r, fl_s_nxt;
  logic [CAP_W-1:0]       freed_r, freed_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  gsa_pkg::req_t          req_r, req_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [GEN_BITS-1:0]    hgen_r, hgen_nxt;

  gsa_pkg::status_t       res_status_r, res_status_nxt;
  logic [IDX_W-1:0]       res_gidx_r, res_gidx_nxt;
  logic [GEN_BITS-1:0]    res_ggen_r, res_ggen_nxt;
  logic                   res_ok_r, res_ok_nxt;
  logic [CAP_W-1:0]       res_freed_r, res_freed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  gsa_pkg::status_t       out_status_r, out_status_nxt;
  logic [IDX_W-1:0]       out_gidx_r, out_gidx_nxt;
  logic [GEN_BITS-1:0]    out_ggen_r, out_ggen_nxt;
  logic                   out_ok_r, out_ok_nxt;
  logic [CAP_W-1:0]       out_freed_r, out_freed_nxt;

  logic                   g_we;
  logic [IDX_W-1:0]       g_waddr, g_raddr;
  logic [GW-1:0]          g_wdata, g_rdata;
  logic                   f_we;
  logic [IDX_W-1:0]       f_waddr, f_raddr, f_wdata, f_rdata;
  logic                   p_we;
  logic [IDX_W-1:0]       p_waddr, p_raddr, p_wdata, p_rdata;

  logic                   out_free;
  logic                   acc;
  logic [CAP_W-1:0]       cap_lim;
  logic [CAP_W-1:0]       ftop_m1;
  logic                   hv;

  gsa_ram #(.WIDTH(GW), .DEPTH(MAX_SLOTS)) u_gen_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  gsa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  gsa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_pend_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign acc       = in_valid && in_ready;
  assign cap_lim   = (32'(cap_cfg_r) > 32'(MAX_SLOTS)) ? MAX_C : CAP_W'(cap_cfg_r);
  assign ftop_m1   = free_top_r - 1'b1;
  assign hv        = ({1'b0, idx_r} < active_cap_r) && g_rdata[GEN_BITS] &&
                     (g_rdata[GEN_BITS-1:0] == hgen_r);

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_given_index      = out_gidx_r;
  assign out_given_generation = out_ggen_r;
  assign out_handle_ok        = out_ok_r;
  assign out_freed_count      = out_freed_r;

  always_comb begin
    state_nxt      = state_r;
    active_cap_nxt = active_cap_r;
    free_top_nxt   = free_top_r;
    pend_cnt_nxt   = pend_cnt_r;
    clr_ptr_nxt    = clr_ptr_r;
    clr_rsp_nxt    = clr_rsp_r;
    fl_i_nxt       = fl_i_r;
    fl_v1_nxt      = fl_v1_r;
    fl_v2_nxt      = fl_v2_r;
    fl_s_nxt       = fl_s_r;
    freed_nxt      = freed_r;
    slot_nxt       = slot_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    hgen_nxt       = hgen_r;
    res_status_nxt = res_status_r;
    res_gidx_nxt   = res_gidx_r;
    res_ggen_nxt   = res_ggen_r;
    res_ok_nxt     = res_ok_r;
    res_freed_nxt  = res_freed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_gidx_nxt   = out_gidx_r;
    out_ggen_nxt   = out_ggen_r;
    out_ok_nxt     = out_ok_r;
    out_freed_nxt  = out_freed_r;

    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    g_raddr = in_slot_index;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = ftop_m1[IDX_W-1:0];
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_raddr = fl_i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
      end
      S_CPOP: begin
        g_raddr   = f_rdata;
        slot_nxt  = f_rdata;
        state_nxt = S_CREATE;
      end
      S_CREATE: begin
        g_we         = 1'b1;
        g_waddr      = slot_r;
        g_wdata      = {1'b1, g_rdata[GEN_BITS-1:0]};
        res_gidx_nxt = slot_r;
        res_ggen_nxt = g_rdata[GEN_BITS-1:0];
        state_nxt    = S_DONE;
      end
      S_CHK: begin
        res_ok_nxt = hv;
        if (req_r == gsa_pkg::REQ_DESTROY) begin
          if (hv && (pend_cnt_r < MAX_C)) begin
            g_we         = 1'b1;
            g_waddr      = idx_r;
            g_wdata      = {1'b1, GEN_BITS'(g_rdata[GEN_BITS-1:0] + 1'b1)};
            p_we         = 1'b1;
            p_waddr      = pend_cnt_r[IDX_W-1:0];
            p_wdata      = idx_r;
            pend_cnt_nxt = pend_cnt_r + 1'b1;
          end else begin
            res_status_nxt = gsa_pkg::ST_INVALID;
          end
        end
        state_nxt = S_DONE;
      end
      S_FLUSH: begin
        if (fl_i_r < pend_cnt_r) begin
          fl_i_nxt  = fl_i_r + 1'b1;
          fl_v1_nxt = 1'b1;
        end else begin
          fl_v1_nxt = 1'b0;
        end
        if (fl_v1_r) begin
          g_raddr   = p_rdata;
          fl_s_nxt  = p_rdata;
          fl_v2_nxt = 1'b1;
        end else begin
          fl_v2_nxt = 1'b0;
        end
        if (fl_v2_r) begin
          g_we    = 1'b1;
          g_waddr = fl_s_r;
          g_wdata = {1'b0, g_rdata[GEN_BITS-1:0]};
          if (free_top_r < MAX_C) begin
            f_we         = 1'b1;
            f_waddr      = free_top_r[IDX_W-1:0];
            f_wdata      = fl_s_r;
            free_top_nxt = free_top_r + 1'b1;
            freed_nxt    = freed_r + 1'b1;
          end
        end
        if ((fl_i_r == pend_cnt_r) && !fl_v1_r && !fl_v2_r) begin
          res_freed_nxt = freed_r;
          pend_cnt_nxt  = '0;
          state_nxt     = S_DONE;
        end
      end
      S_CLEAR: begin
        g_we        = 1'b1;
        g_waddr     = clr_ptr_r[IDX_W-1:0];
        g_wdata     = '0;
        f_we        = 1'b1;
        f_waddr     = clr_ptr_r[IDX_W-1:0];
        f_wdata     = clr_ptr_r[IDX_W-1:0];
        clr_ptr_nxt = CAP_W'(clr_ptr_r + 1'b1);
        if (CAP_W'(clr_ptr_r + 1'b1) == active_cap_r) begin
          clr_rsp_nxt = 1'b0;
          state_nxt   = clr_rsp_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_gidx_nxt   = res_gidx_r;
          out_ggen_nxt   = res_ggen_r;
          out_ok_nxt     = res_ok_r;
          out_freed_nxt  = res_freed_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (acc) begin
      req_nxt        = in_req_type;
      idx_nxt        = in_slot_index;
      hgen_nxt       = in_handle_generation;
      res_status_nxt = gsa_pkg::ST_OK;
      res_gidx_nxt   = '0;
      res_ggen_nxt   = '0;
      res_ok_nxt     = 1'b0;
      res_freed_nxt  = '0;
      unique case (in_req_type)
        gsa_pkg::REQ_CREATE: begin
          if (free_top_r == '0) begin
            res_status_nxt = gsa_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            free_top_nxt = ftop_m1;
            state_nxt    = S_CPOP;
          end
        end
        gsa_pkg::REQ_DESTROY, gsa_pkg::REQ_CHECK: begin
          state_nxt = S_CHK;
        end
        gsa_pkg::REQ_FLUSH: begin
          fl_i_nxt  = '0;
          fl_v1_nxt = 1'b0;
          fl_v2_nxt = 1'b0;
          freed_nxt = '0;
          state_nxt = S_FLUSH;
        end
        gsa_pkg::REQ_INIT: begin
          active_cap_nxt = cap_lim;
          free_top_nxt   = cap_lim;
          pend_cnt_nxt   = '0;
          clr_ptr_nxt    = '0;
          clr_rsp_nxt    = 1'b1;
          state_nxt      = (cap_lim == '0) ? S_DONE : S_CLEAR;
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cap_cfg_r    <= gsa_pkg::CFG_CAP_RESET;
      active_cap_r <= RST_CAP;
      free_top_r   <= RST_CAP;
      pend_cnt_r   <= '0;
      clr_ptr_r    <= '0;
      clr_rsp_r    <= 1'b0;
      fl_i_r       <= '0;
      fl_v1_r      <= 1'b0;
      fl_v2_r      <= 1'b0;
      freed_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_cfg_r <= cfg_slot_capacity;
      end
      active_cap_r <= active_cap_nxt;
      free_top_r   <= free_top_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      clr_rsp_r    <= clr_rsp_nxt;
      fl_i_r       <= fl_i_nxt;
      fl_v1_r      <= fl_v1_nxt;
      fl_v2_r      <= fl_v2_nxt;
      freed_r      <= freed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_s_r       <= fl_s_nxt;
    slot_r       <= slot_nxt;
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    hgen_r       <= hgen_nxt;
    res_status_r <= res_status_nxt;
    res_gidx_r   <= res_gidx_nxt;
    res_ggen_r   <= res_ggen_nxt;
    res_ok_r     <= res_ok_nxt;
    res_freed_r  <= res_freed_nxt;
    out_status_r <= out_status_nxt;
    out_gidx_r   <= out_gidx_nxt;
    out_ggen_r   <= out_ggen_nxt;
    out_ok_r     <= out_ok_nxt;
    out_freed_r  <= out_freed_nxt;
  end

endmodule

// ===== tb/generational_slot_allocator_test.sv =====
`timescale 1ns / 100ps

module generational_slot_allocator_test;

  localparam int SLOTS = 256;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    gsa_pkg::status_t status;
    logic [7:0]       idx;
    logic [15:0]      gen;
    logic             ok;
    logic [8:0]       freed;
  } answer_t;

  class slot_map_shadow;
    logic [15:0] gen_of [SLOTS];
    bit          live [SLOTS];
    logic [7:0]  free_stack [SLOTS];
    int          free_top;
    logic [7:0]  pending [SLOTS];
    int          pending_cnt;
    int          cap_reg;
    int          active_cap;
    answer_t     owed [$];
    int          errors;

    function new();
      cap_reg = gsa_pkg::CFG_CAP_RESET;
      errors = 0;
      clear_map();
    endfunction

    function void clear_map();
      active_cap = (cap_reg > SLOTS) ? SLOTS : cap_reg;
      for (int i = 0; i < SLOTS; i++) begin
        gen_of[i] = '0;
        live[i] = 1'b0;
        free_stack[i] = (i < active_cap) ? i[7:0] : 8'd0;
        pending[i] = '0;
      end
      free_top = active_cap;
      pending_cnt = 0;
    endfunction

    function bit handle_valid(int idx, logic [15:0] g);
      return idx < active_cap && live[idx] && gen_of[idx] == g;
    endfunction

    function int pick_live();
      int cand [$];
      for (int i = 0; i < active_cap; i++)
        if (live[i]) cand = {cand, i};
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function void note_request(gsa_pkg::req_t req, logic [7:0] idx, logic [15:0] g);
      answer_t a;
      int s;
      a = '0;
      case (req)
        gsa_pkg::REQ_CREATE: begin
          if (free_top == 0) begin
            a.status = gsa_pkg::ST_FULL;
          end else begin
            free_top--;
            s = free_stack[free_top];
            live[s] = 1'b1;
            a.idx = s[7:0];
            a.gen = gen_of[s];
          end
        end
        gsa_pkg::REQ_DESTROY: begin
          if (handle_valid(idx, g)) begin
            a.ok = 1'b1;
            if (pending_cnt < SLOTS) begin
              gen_of[idx] = gen_of[idx] + 16'd1;
              pending[pending_cnt] = idx;
              pending_cnt++;
            end else begin
              a.status = gsa_pkg::ST_INVALID;
            end
          end else begin
            a.status = gsa_pkg::ST_INVALID;
          end
        end
        gsa_pkg::REQ_CHECK: a.ok = handle_valid(idx, g);
        gsa_pkg::REQ_FLUSH: begin
          for (int i = 0; i < pending_cnt; i++) begin
            s = pending[i];
            live[s] = 1'b0;
            if (free_top < SLOTS) begin
              free_stack[free_top] = s[7:0];
              free_top++;
              a.freed = a.freed + 9'd1;
            end
          end
          pending_cnt = 0;
        end
        gsa_pkg::REQ_INIT: clear_map();
        default: ;
      endcase
      owed = {owed, a};
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (owed.size() == 0) begin
        $error("unexpected beat: status %0d given_index %0d", got.status, got.idx);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $error("given_index expected %0d actual %0d", want.idx, got.idx);
        errors++;
      end
      if (got.gen !== want.gen) begin
        $error("given_generation expected %0d actual %0d", want.gen, got.gen);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("handle_ok expected %0d actual %0d", want.ok, got.ok);
        errors++;
      end
      if (got.freed !== want.freed) begin
        $error("freed_count expected %0d actual %0d", want.freed, got.freed);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  gsa_pkg::cfg_t    cfg_slot_capacity = gsa_pkg::CFG_CAP_RESET;
  logic             in_valid = 1'b0;
  logic             in_ready;
  gsa_pkg::req_t    in_req_type = gsa_pkg::REQ_CREATE;
  logic [7:0]       in_slot_index = '0;
  logic [15:0]      in_handle_generation = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  gsa_pkg::status_t out_status;
  logic [7:0]       out_given_index;
  logic [15:0]      out_given_generation;
  logic             out_handle_ok;
  logic [8:0]       out_freed_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  slot_map_shadow sb = new();

  generational_slot_allocator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_slot_capacity    (cfg_slot_capacity),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_slot_index        (in_slot_index),
    .in_handle_generation (in_handle_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_given_index      (out_given_index),
    .out_given_generation (out_given_generation),
    .out_handle_ok        (out_handle_ok),
    .out_freed_count      (out_freed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_status, out_given_index, out_given_generation,
                       out_handle_ok, out_freed_count});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(gsa_pkg::req_t req, logic [7:0] idx, logic [15:0] g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_slot_index <= idx;
    in_handle_generation <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, idx, g);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(gsa_pkg::cfg_t v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_slot_capacity <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.cap_reg = v;
  endtask

  task automatic flood_destroys(int count);
    int slot;
    slot = sb.pick_live();
    if (slot < 0) begin
      send_request(gsa_pkg::REQ_CREATE, '0, '0);
      slot = sb.pick_live();
    end
    repeat (count) send_request(gsa_pkg::REQ_DESTROY, slot[7:0], sb.gen_of[slot]);
    send_request(gsa_pkg::REQ_FLUSH, '0, '0);
  endtask

  task automatic run_phase(int idle_s, int stall_r, gsa_pkg::cfg_t cap, int count, bit flood);
    int n;
    int choice;
    int slot;
    int k;
    send_idle_pct = idle_s;
    recv_stall_pct = stall_r;
    write_capacity(cap);
    send_request(gsa_pkg::REQ_INIT, '0, '0);
    if (flood) flood_destroys(260);
    n = 0;
    while (n < count) begin
      choice = $urandom_range(99);
      slot = sb.pick_live();
      if (choice >= 25 && choice < 70 && slot < 0) choice = 0;
      if (choice < 25) begin
        send_request(gsa_pkg::REQ_CREATE, 8'($urandom_range(255)),
                     16'($urandom_range(65535)));
        n++;
      end else if (choice < 45) begin
        send_request(gsa_pkg::REQ_DESTROY, slot[7:0], sb.gen_of[slot]);
        n++;
      end else if (choice < 60) begin
        send_request(gsa_pkg::REQ_CHECK, slot[7:0], sb.gen_of[slot]);
        n++;
      end else if (choice < 70) begin
        send_request($urandom_range(1) ? gsa_pkg::REQ_CHECK : gsa_pkg::REQ_DESTROY,
                     slot[7:0],
                     $urandom_range(1) ? sb.gen_of[slot] - 16'd1
                                       : 16'($urandom_range(65535)));
        n++;
      end else if (choice < 78) begin
        send_request(gsa_pkg::REQ_FLUSH, '0, '0);
        n++;
      end else if (choice < 90) begin
        send_request(gsa_pkg::req_t'($urandom_range(2**gsa_pkg::REQ_W - 1)),
                     8'($urandom_range(255)), 16'($urandom_range(65535)));
        n++;
      end else if (choice < 97 && slot >= 0) begin
        k = $urandom_range(6, 2);
        repeat (k) send_request(gsa_pkg::REQ_DESTROY, slot[7:0], sb.gen_of[slot]);
        n += k;
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(gsa_pkg::REQ_CHECK, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_DESTROY, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CHECK, 8'd255, 16'd0);
    send_request(gsa_pkg::REQ_CHECK, 8'd255, 16'd1);
    send_request(gsa_pkg::REQ_DESTROY, 8'd255, 16'd0);
    send_request(gsa_pkg::REQ_CHECK, 8'd255, 16'd1);
    send_request(gsa_pkg::REQ_DESTROY, 8'd255, 16'd1);
    send_request(gsa_pkg::REQ_FLUSH, 8'd255, 16'hFFFF);
    send_request(gsa_pkg::REQ_CHECK, 8'd255, 16'd2);
    send_request(gsa_pkg::REQ_CHECK, 8'd0, 16'hFFFF);
    for (int r = gsa_pkg::REQ_INIT + 1; r <= 2**gsa_pkg::REQ_W - 1; r++)
      send_request(gsa_pkg::req_t'(r), 8'd255, 16'hFFFF);
    send_request(gsa_pkg::REQ_INIT, 8'd0, 16'd0);

    write_capacity(9'd1);
    send_request(gsa_pkg::REQ_INIT, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_DESTROY, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_FLUSH, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CHECK, 8'd1, 16'd0);

    write_capacity(9'd0);
    send_request(gsa_pkg::REQ_INIT, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CHECK, 8'd0, 16'd0);

    write_capacity(9'd511);
    send_request(gsa_pkg::REQ_INIT, 8'd0, 16'd0);
    send_request(gsa_pkg::REQ_CREATE, 8'd0, 16'd0);

    run_phase(0, 0, 9'd8, 280, 1'b0);
    run_phase(55, 0, 9'd3, 280, 1'b1);
    run_phase(0, 55, 9'd256, 280, 1'b0);
    run_phase(35, 35, 9'd16, 280, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
